@@ design/wgm_pkg.sv @@
package wgm_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_COUNT = 5;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int M_W = 17;
    localparam int Q_W = 17;
    localparam int V_W = $clog2(255 * TABLE_DEPTH + 1);
    localparam int DIV_W = (V_W > Q_W) ? V_W : Q_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam int STAGES = 8;

    localparam logic [8:0] ALPHA_ONE = 9'd256;
    localparam logic [31:0] MID_GREY4 = 32'h8080_8080;
    localparam logic [7:0] OPAQUE = 8'hFF;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_LOAD = 1'b1
    } opcode_t;

    typedef enum logic [2:0]
    {
        TBL_COLOUR = 3'd0,
        TBL_DEPTH = 3'd1,
        TBL_DISP = 3'd2,
        TBL_METAL = 3'd3,
        TBL_SMOOTH = 3'd4
    } table_sel_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_ALPHA = 1'b0,
        CFG_TOL = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        opcode_t op;
        logic [2:0] sel;
        logic [7:0] idx;
        logic [31:0] entry;
    } load_t;

    typedef struct packed
    {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed
    {
        load_t ld;
        rgb_t rgb;
    } carry_t;

    typedef struct packed
    {
        logic [31:0] colour;
        logic [31:0] depth;
        logic [31:0] disp;
        logic [7:0] metal_red;
        logic [7:0] smooth_red;
    } row_t;

    function automatic logic [7:0] abs_diff(logic [7:0] x, logic [7:0] y);
        return (x > y) ? (x - y) : (y - x);
    endfunction

    // quotient by 255, low by at most one
    function automatic logic [DIV_W-1:0] div255_est(logic [DIV_W-1:0] v);
        logic [DIV_W+8:0] p;
        p = {9'b0, v} + ({9'b0, v} << 8);
        return DIV_W'(p >> 16);
    endfunction

    function automatic logic [DIV_W-1:0] div255_fix(logic [DIV_W-1:0] v,
                                                     logic [DIV_W-1:0] est);
        logic [DIV_W+8:0] rem;
        rem = {9'b0, v} - (({9'b0, est} << 8) - {9'b0, est});
        return (rem >= (DIV_W + 9)'(255)) ? DIV_W'(est + 1'b1) : est;
    endfunction

endpackage

@@ design/weathering_gradient_mapper.sv @@
// Weathering gradient mapper. Takes one request per clock, pixel or table load,
// while pixel_stall is low, and returns each pixel's result in request order;
// loads give no result. The rate is set by the single gradient memory, which is
// read or written once per cycle in stage seven; it keeps all five tables as
// lanes of one row, and a load to one of the five tables writes one lane. Table
// entries are undefined until loaded, and there is no clearing pass after reset.
// Write configuration only while no request is in flight.
module weathering_gradient_mapper
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wgm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic                                opcode,
    input  logic [7:0]                          base_red,
    input  logic [7:0]                          base_green,
    input  logic [7:0]                          base_blue,
    input  logic [7:0]                          noise_level,
    input  logic [2:0]                          table_select,
    input  logic [7:0]                          table_index,
    input  logic [31:0]                         entry_rgba,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [31:0]                         colour_rgba,
    output logic [31:0]                         depth_rgba,
    output logic [31:0]                         disp_rgba,
    output logic [31:0]                         material_rgba,
    output logic [23:0]                         base_out_rgb,
    output logic                                passed_through
);

    logic [8:0] alpha_reg;
    logic [7:0] tol_reg;

    logic [wgm_pkg::STAGES-1:0] vld_reg;
    logic [wgm_pkg::STAGES-1:0] vld_next;
    logic [wgm_pkg::STAGES-1:0] mv;
    logic [wgm_pkg::STAGES:0] take;
    logic accept;
    logic s7_is_load;
    logic out_vld_reg;
    logic out_vld_next;

    wgm_pkg::carry_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg;
    logic [7:0] s1_noise_reg;
    logic s2_grey_reg, s3_grey_reg, s4_grey_reg, s5_grey_reg, s6_grey_reg, s7_grey_reg;
    logic [wgm_pkg::M_W-1:0] s2_mix_reg;
    logic [wgm_pkg::Q_W-1:0] s3_q_reg, s4_q_reg;
    logic [wgm_pkg::DIV_W-1:0] s4_est_reg, s6_est_reg;
    logic [7:0] s5_d_reg, s6_d_reg, s7_d_reg, s8_d_reg;
    logic [wgm_pkg::V_W-1:0] s6_v_reg;
    logic [wgm_pkg::ADDR_W-1:0] s7_row_reg;
    wgm_pkg::rgb_t s8_rgb_reg;
    logic s8_grey_reg;
    wgm_pkg::row_t rd_data_reg;

    wgm_pkg::row_t mem [wgm_pkg::TABLE_DEPTH];

    logic [31:0] colour_reg, depth_reg, disp_reg, material_reg;
    logic [23:0] base_out_reg;
    logic passed_reg;

    logic grey_c;
    logic [8:0] alpha_c;
    logic [8:0] alpha_inv_c;
    logic [wgm_pkg::M_W-1:0] mix_c;
    logic [24:0] prod_c;
    logic [wgm_pkg::DIV_W-1:0] d0_c;
    logic [7:0] d_c;
    logic [wgm_pkg::V_W-1:0] v_c;
    logic [wgm_pkg::DIV_W-1:0] row0_c;
    logic [wgm_pkg::ADDR_W-1:0] row_c;
    logic load_ok_c;
    wgm_pkg::carry_t in_c;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
            tol_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wgm_pkg::CFG_ALPHA: alpha_reg <= cfg_data;
                wgm_pkg::CFG_TOL: tol_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // flow control, bubbles collapse
    assign s7_is_load = (s7_reg.ld.op == wgm_pkg::OP_LOAD);

    always_comb
    begin
        take[8] = !out_vld_reg || !result_stall;
        mv[7] = vld_reg[7] && take[8];
        take[7] = !vld_reg[7] || mv[7];
        mv[6] = vld_reg[6] && (s7_is_load || take[7]);
        take[6] = !vld_reg[6] || mv[6];
        mv[5] = vld_reg[5] && take[6];
        take[5] = !vld_reg[5] || mv[5];
        mv[4] = vld_reg[4] && take[5];
        take[4] = !vld_reg[4] || mv[4];
        mv[3] = vld_reg[3] && take[4];
        take[3] = !vld_reg[3] || mv[3];
        mv[2] = vld_reg[2] && take[3];
        take[2] = !vld_reg[2] || mv[2];
        mv[1] = vld_reg[1] && take[2];
        take[1] = !vld_reg[1] || mv[1];
        mv[0] = vld_reg[0] && take[1];
        take[0] = !vld_reg[0] || mv[0];
    end

    assign pixel_stall = !take[0];
    assign accept = pixel_valid && take[0];

    always_comb
    begin
        vld_next[0] = accept ? 1'b1 : (mv[0] ? 1'b0 : vld_reg[0]);
        for (int k = 1; k < wgm_pkg::STAGES - 1; k++)
        begin
            vld_next[k] = mv[k-1] ? 1'b1 : (mv[k] ? 1'b0 : vld_reg[k]);
        end
        vld_next[7] = (mv[6] && !s7_is_load) ? 1'b1 : (mv[7] ? 1'b0 : vld_reg[7]);
        out_vld_next = mv[7] ? 1'b1 : ((out_vld_reg && !result_stall) ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // datapath
    always_comb
    begin
        in_c.ld.op = wgm_pkg::opcode_t'(opcode);
        in_c.ld.sel = table_select;
        in_c.ld.idx = table_index;
        in_c.ld.entry = entry_rgba;
        in_c.rgb.red = base_red;
        in_c.rgb.green = base_green;
        in_c.rgb.blue = base_blue;

        grey_c = (wgm_pkg::abs_diff(s1_reg.rgb.red, s1_reg.rgb.green) <= tol_reg)
              && (wgm_pkg::abs_diff(s1_reg.rgb.red, s1_reg.rgb.blue) <= tol_reg)
              && (wgm_pkg::abs_diff(s1_reg.rgb.blue, s1_reg.rgb.green) <= tol_reg);
        alpha_c = (alpha_reg > wgm_pkg::ALPHA_ONE) ? wgm_pkg::ALPHA_ONE : alpha_reg;
        alpha_inv_c = wgm_pkg::ALPHA_ONE - alpha_c;
        mix_c = (({8'b0, alpha_inv_c} << 8) - {8'b0, alpha_inv_c})
              + ((wgm_pkg::M_W'(alpha_c) * wgm_pkg::M_W'(s1_noise_reg)) << 1);

        prod_c = 25'(s2_reg.rgb.red) * 25'(s2_mix_reg);

        d0_c = wgm_pkg::div255_fix(wgm_pkg::DIV_W'(s4_q_reg), s4_est_reg);
        d_c = (d0_c > wgm_pkg::DIV_W'(255)) ? 8'hFF : d0_c[7:0];

        v_c = wgm_pkg::V_W'(s5_d_reg) * wgm_pkg::V_W'(wgm_pkg::TABLE_DEPTH);

        row0_c = wgm_pkg::div255_fix(wgm_pkg::DIV_W'(s6_v_reg), s6_est_reg);
        row_c = (row0_c > wgm_pkg::DIV_W'(wgm_pkg::TABLE_DEPTH - 1))
              ? wgm_pkg::ADDR_W'(wgm_pkg::TABLE_DEPTH - 1) : wgm_pkg::ADDR_W'(row0_c);

        load_ok_c = (32'(s7_reg.ld.idx) < wgm_pkg::TABLE_DEPTH);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= in_c;
            s1_noise_reg <= noise_level;
        end
        if (mv[0])
        begin
            s2_reg <= s1_reg;
            s2_grey_reg <= grey_c;
            s2_mix_reg <= mix_c;
        end
        if (mv[1])
        begin
            s3_reg <= s2_reg;
            s3_grey_reg <= s2_grey_reg;
            s3_q_reg <= prod_c[24:8];
        end
        if (mv[2])
        begin
            s4_reg <= s3_reg;
            s4_grey_reg <= s3_grey_reg;
            s4_q_reg <= s3_q_reg;
            s4_est_reg <= wgm_pkg::div255_est(wgm_pkg::DIV_W'(s3_q_reg));
        end
        if (mv[3])
        begin
            s5_reg <= s4_reg;
            s5_grey_reg <= s4_grey_reg;
            s5_d_reg <= d_c;
        end
        if (mv[4])
        begin
            s6_reg <= s5_reg;
            s6_grey_reg <= s5_grey_reg;
            s6_d_reg <= s5_d_reg;
            s6_v_reg <= v_c;
            s6_est_reg <= wgm_pkg::div255_est(wgm_pkg::DIV_W'(v_c));
        end
        if (mv[5])
        begin
            s7_reg <= s6_reg;
            s7_grey_reg <= s6_grey_reg;
            s7_d_reg <= s6_d_reg;
            s7_row_reg <= row_c;
        end
        if (mv[6] && !s7_is_load)
        begin
            s8_rgb_reg <= s7_reg.rgb;
            s8_grey_reg <= s7_grey_reg;
            s8_d_reg <= s7_d_reg;
        end
    end

    // gradient memory, one lane per table
    always_ff @(posedge clk)
    begin
        if (mv[6] && s7_is_load && load_ok_c)
        begin
            case (s7_reg.ld.sel)
                wgm_pkg::TBL_COLOUR:
                    mem[wgm_pkg::ADDR_W'(s7_reg.ld.idx)].colour <= s7_reg.ld.entry;
                wgm_pkg::TBL_DEPTH:
                    mem[wgm_pkg::ADDR_W'(s7_reg.ld.idx)].depth <= s7_reg.ld.entry;
                wgm_pkg::TBL_DISP:
                    mem[wgm_pkg::ADDR_W'(s7_reg.ld.idx)].disp <= s7_reg.ld.entry;
                wgm_pkg::TBL_METAL:
                    mem[wgm_pkg::ADDR_W'(s7_reg.ld.idx)].metal_red <= s7_reg.ld.entry[31:24];
                wgm_pkg::TBL_SMOOTH:
                    mem[wgm_pkg::ADDR_W'(s7_reg.ld.idx)].smooth_red <= s7_reg.ld.entry[31:24];
                default: ;
            endcase
        end
        if (mv[6] && !s7_is_load)
        begin
            rd_data_reg <= mem[s7_row_reg];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (mv[7])
        begin
            if (!s8_grey_reg)
            begin
                colour_reg <= {s8_rgb_reg, wgm_pkg::OPAQUE};
                depth_reg <= wgm_pkg::MID_GREY4;
                disp_reg <= wgm_pkg::MID_GREY4;
                material_reg <= wgm_pkg::MID_GREY4;
                base_out_reg <= s8_rgb_reg;
                passed_reg <= 1'b1;
            end
            else
            begin
                colour_reg <= rd_data_reg.colour;
                depth_reg <= ~rd_data_reg.depth;
                disp_reg <= rd_data_reg.disp;
                material_reg <= {rd_data_reg.metal_red, 8'h00,
                                 rd_data_reg.smooth_red, rd_data_reg.smooth_red};
                base_out_reg <= {s8_d_reg, s8_d_reg, s8_d_reg};
                passed_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_vld_reg;
    assign colour_rgba = colour_reg;
    assign depth_rgba = depth_reg;
    assign disp_rgba = disp_reg;
    assign material_rgba = material_reg;
    assign base_out_rgb = base_out_reg;
    assign passed_through = passed_reg;

    // checks
    a_first_stage_free: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> !pixel_stall)
        else $error("input stalled with an empty first stage");

    a_pass_pack: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && passed_through) |->
            (depth_rgba == wgm_pkg::MID_GREY4 && material_rgba == wgm_pkg::MID_GREY4
             && base_out_rgb == colour_rgba[31:8]))
        else $error("pass-through result badly packed");

    a_grey_pack: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !passed_through) |->
            (base_out_rgb[23:16] == base_out_rgb[7:0]
             && base_out_rgb[15:8] == base_out_rgb[7:0]
             && material_rgba[23:16] == 8'h00
             && material_rgba[15:8] == material_rgba[7:0]))
        else $error("grey result badly packed");

    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[7] && !result_valid) |=> result_valid)
        else $error("result not moved into an empty output register");

endmodule

@@ tb/tb_weathering_gradient_mapper.sv @@
`timescale 1ns / 1ps

module tb_weathering_gradient_mapper;

    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT = 38;
    localparam int REPORT_CAP = 40;

    typedef struct packed
    {
        logic [31:0] colour;
        logic [31:0] depth;
        logic [31:0] disp;
        logic [31:0] material;
        logic [23:0] base;
        logic passed;
    } maps_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [wgm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [wgm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic pixel_valid;
    logic pixel_stall;
    logic opcode;
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] noise_level;
    logic [2:0] table_select;
    logic [7:0] table_index;
    logic [31:0] entry_rgba;
    logic result_valid;
    logic result_stall;
    logic [31:0] colour_rgba;
    logic [31:0] depth_rgba;
    logic [31:0] disp_rgba;
    logic [31:0] material_rgba;
    logic [23:0] base_out_rgb;
    logic passed_through;

    logic [31:0] grad_rows [wgm_pkg::TABLE_COUNT][wgm_pkg::TABLE_DEPTH];
    logic [8:0] alpha_q8;
    logic [7:0] grey_tol;
    maps_t pending_maps[$];

    int errors;
    int pixels_checked;
    int passthru_seen;
    int loads_sent;
    int settings_used;
    int cycles;
    bit idle_on;
    bit stall_on;

    weathering_gradient_mapper DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .opcode(opcode),
        .base_red(base_red),
        .base_green(base_green),
        .base_blue(base_blue),
        .noise_level(noise_level),
        .table_select(table_select),
        .table_index(table_index),
        .entry_rgba(entry_rgba),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .colour_rgba(colour_rgba),
        .depth_rgba(depth_rgba),
        .disp_rgba(disp_rgba),
        .material_rgba(material_rgba),
        .base_out_rgb(base_out_rgb),
        .passed_through(passed_through)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_maps.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall = stall_on && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < REPORT_CAP)
            $display("mismatch at cycle %0d: %s got %h want %h", cycles, field, got, want);
        errors++;
    endtask

    function automatic logic [7:0] chan_gap(input logic [7:0] x, input logic [7:0] y);
        return (x > y) ? x - y : y - x;
    endfunction

    function automatic maps_t weather_pixel(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [7:0] n);
        maps_t m;
        int unsigned a;
        int unsigned mix;
        int unsigned deg;
        int unsigned row;
        logic [31:0] metal;
        logic [31:0] smooth;
        if (chan_gap(r, g) > grey_tol || chan_gap(r, b) > grey_tol ||
            chan_gap(b, g) > grey_tol)
        begin
            m.colour = {r, g, b, wgm_pkg::OPAQUE};
            m.depth = wgm_pkg::MID_GREY4;
            m.disp = wgm_pkg::MID_GREY4;
            m.material = wgm_pkg::MID_GREY4;
            m.base = {r, g, b};
            m.passed = 1'b1;
            return m;
        end
        a = (alpha_q8 > wgm_pkg::ALPHA_ONE) ? 256 : alpha_q8;
        mix = (256 - a) * 255 + 2 * a * n;
        deg = (r * mix) / (256 * 255);
        if (deg > 255)
            deg = 255;
        row = (deg * wgm_pkg::TABLE_DEPTH) / 255;
        if (row > wgm_pkg::TABLE_DEPTH - 1)
            row = wgm_pkg::TABLE_DEPTH - 1;
        metal = grad_rows[wgm_pkg::TBL_METAL][row];
        smooth = grad_rows[wgm_pkg::TBL_SMOOTH][row];
        m.colour = grad_rows[wgm_pkg::TBL_COLOUR][row];
        m.depth = ~grad_rows[wgm_pkg::TBL_DEPTH][row];
        m.disp = grad_rows[wgm_pkg::TBL_DISP][row];
        m.material = {metal[31:24], 8'h00, smooth[31:24], smooth[31:24]};
        m.base = {3{deg[7:0]}};
        m.passed = 1'b0;
        return m;
    endfunction

    always @(posedge clk)
    begin : check_results
        maps_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_maps.size() == 0)
                report_mismatch("unexpected result", 32'd1, 32'd0);
            else
            begin
                want = pending_maps.pop_front();
                if (colour_rgba !== want.colour)
                    report_mismatch("colour_rgba", colour_rgba, want.colour);
                if (depth_rgba !== want.depth)
                    report_mismatch("depth_rgba", depth_rgba, want.depth);
                if (disp_rgba !== want.disp)
                    report_mismatch("disp_rgba", disp_rgba, want.disp);
                if (material_rgba !== want.material)
                    report_mismatch("material_rgba", material_rgba, want.material);
                if (base_out_rgb !== want.base)
                    report_mismatch("base_out_rgb", {8'h00, base_out_rgb}, {8'h00, want.base});
                if (passed_through !== want.passed)
                    report_mismatch("passed_through", {31'd0, passed_through},
                                    {31'd0, want.passed});
                pixels_checked++;
                if (want.passed)
                    passthru_seen++;
            end
        end
    end

    task automatic send_request(input wgm_pkg::opcode_t op, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b,
                                input logic [7:0] n, input logic [2:0] sel,
                                input logic [7:0] idx, input logic [31:0] entry);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            pixel_valid = 1'b0;
            @(negedge clk);
        end
        opcode = op;
        base_red = r;
        base_green = g;
        base_blue = b;
        noise_level = n;
        table_select = sel;
        table_index = idx;
        entry_rgba = entry;
        pixel_valid = 1'b1;
        do
            @(posedge clk);
        while (pixel_stall);
        if (op == wgm_pkg::OP_LOAD)
        begin
            if (sel < wgm_pkg::TABLE_COUNT && idx < wgm_pkg::TABLE_DEPTH)
                grad_rows[sel][idx] = entry;
            loads_sent++;
        end
        else
            pending_maps.insert(pending_maps.size(), weather_pixel(r, g, b, n));
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] n);
        send_request(wgm_pkg::OP_PIXEL, r, g, b, n, 3'($urandom), 8'($urandom), $urandom);
    endtask

    task automatic send_load(input logic [2:0] sel, input logic [7:0] idx,
                             input logic [31:0] entry);
        send_request(wgm_pkg::OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), sel, idx, entry);
    endtask

    task automatic drain_pipeline;
        @(negedge clk);
        pixel_valid = 1'b0;
        while (pending_maps.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input wgm_pkg::cfg_index_t which, input logic [8:0] value);
        cfg_we = 1'b1;
        cfg_index = which;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (which == wgm_pkg::CFG_ALPHA)
            alpha_q8 = value;
        else
            grey_tol = value[7:0];
    endtask

    task automatic set_config(input logic [8:0] alpha, input logic [7:0] tol);
        drain_pipeline();
        write_reg(wgm_pkg::CFG_ALPHA, alpha);
        write_reg(wgm_pkg::CFG_TOL, {1'b0, tol});
        settings_used++;
    endtask

    task automatic test_table_fill;
        logic [31:0] entry;
        for (int t = 0; t < wgm_pkg::TABLE_COUNT; t++)
        begin
            for (int i = 0; i < wgm_pkg::TABLE_DEPTH; i++)
            begin
                if (i == 0)
                    entry = 32'h0000_0000;
                else if (i == wgm_pkg::TABLE_DEPTH - 1)
                    entry = 32'hFFFF_FFFF;
                else
                    entry = $urandom;
                send_load(3'(t), 8'(i), entry);
            end
        end
        drain_pipeline();
    endtask

    task automatic test_directed;
        set_config(9'd0, 8'd0);
        send_load(wgm_pkg::TBL_COLOUR, 8'd255, 32'hFFFF_FFFF);
        send_load(wgm_pkg::TBL_DEPTH, 8'd255, 32'h0000_0000);
        send_load(wgm_pkg::TBL_DISP, 8'd255, 32'hA5A5_A5A5);
        send_load(wgm_pkg::TBL_METAL, 8'd255, 32'hFF00_FF00);
        send_load(wgm_pkg::TBL_SMOOTH, 8'd255, 32'h7FFF_FFFF);
        // unknown tables must leave row 255 alone
        send_load(3'd5, 8'd255, 32'hDEAD_BEEF);
        send_load(3'd6, 8'd255, 32'hDEAD_BEEF);
        send_load(3'd7, 8'd255, 32'hDEAD_BEEF);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd17);
        send_pixel(8'd0, 8'd255, 8'd255, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0, 8'd0);
        set_config(9'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd128, 8'd9);
        set_config(9'd256, 8'd255);
        send_pixel(8'd200, 8'd200, 8'd200, 8'd255);
        send_pixel(8'd200, 8'd200, 8'd200, 8'd0);
        // alpha above one saturates
        set_config(9'd511, 8'd0);
        send_pixel(8'd100, 8'd100, 8'd100, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        // tolerance edge: gap equal to tolerance is grey, one more is not
        set_config(9'd128, 8'd10);
        send_pixel(8'd100, 8'd110, 8'd105, 8'd128);
        send_pixel(8'd100, 8'd111, 8'd100, 8'd128);
        drain_pipeline();
    endtask

    task automatic test_random(input int per_phase);
        logic [8:0] alphas [8];
        logic [7:0] tols [8];
        wgm_pkg::opcode_t op;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [2:0] sel;
        int pick;
        int span;
        int lo;
        alphas = '{9'd0, 9'd256, 9'd511, 9'd128, 9'd1, 9'd255, 9'd300, 9'd64};
        tols = '{8'd0, 8'd255, 8'd8, 8'd32, 8'd1, 8'd0, 8'd64, 8'd255};
        for (int ph = 0; ph < 8; ph++)
        begin
            set_config(alphas[ph], tols[ph]);
            idle_on = (ph != 1);
            stall_on = (ph != 1);
            for (int k = 0; k < per_phase; k++)
            begin
                pick = $urandom_range(0, 99);
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
                sel = 3'($urandom_range(0, wgm_pkg::TABLE_COUNT - 1));
                op = wgm_pkg::OP_PIXEL;
                if (pick < 25)
                begin
                    op = wgm_pkg::OP_LOAD;
                    if ($urandom_range(0, 9) == 0)
                        sel = 3'($urandom_range(wgm_pkg::TABLE_COUNT, 7));
                end
                else if (pick < 70)
                begin
                    // channels kept within tolerance so the gradient path is taken
                    span = grey_tol;
                    lo = $urandom_range(0, 255 - span);
                    r = 8'(lo + $urandom_range(0, span));
                    g = 8'(lo + $urandom_range(0, span));
                    b = 8'(lo + $urandom_range(0, span));
                end
                send_request(op, r, g, b, 8'($urandom), sel, 8'($urandom), $urandom);
            end
            idle_on = 1'b1;
            stall_on = 1'b1;
        end
        drain_pipeline();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixel_valid = 1'b0;
        opcode = wgm_pkg::OP_PIXEL;
        base_red = '0;
        base_green = '0;
        base_blue = '0;
        noise_level = '0;
        table_select = '0;
        table_index = '0;
        entry_rgba = '0;
        alpha_q8 = '0;
        grey_tol = '0;
        errors = 0;
        pixels_checked = 0;
        passthru_seen = 0;
        loads_sent = 0;
        settings_used = 0;
        cycles = 0;
        idle_on = 1'b1;
        stall_on = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_table_fill();
        test_directed();
        test_random(37);

        if (pending_maps.size() != 0)
            report_mismatch("results never arrived", pending_maps.size(), 32'd0);
        $display("checked %0d pixel results, %0d of them passed through as non-grey",
                 pixels_checked, passthru_seen);
        $display("sent %0d table loads across %0d alpha and tolerance settings",
                 loads_sent, settings_used);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
